### rtl/olse_pkg.sv
`default_nettype none

package olse_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 5;
    localparam int ENTRY_W  = 5;
    localparam int CMP_W    = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_INSERT     = 3'd2,
        MODE_POP_FRONT  = 3'd3,
        MODE_POP_BACK   = 3'd4,
        MODE_DELETE_KEY = 3'd5,
        MODE_READ_OUT   = 3'd6
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_BADPOS   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_REMOVE,
        S_SCAN,
        S_READ_OUT
    } state_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

endpackage

`default_nettype wire

### rtl/olse_store.sv
`default_nettype none

module olse_store (
    input  wire logic                      clk,
    input  wire olse_pkg::mem_req_t        req,
    output logic [olse_pkg::DATA_W-1:0]    rdata
);

    logic [olse_pkg::DATA_W-1:0] mem [olse_pkg::CAPACITY];
    logic [olse_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/ordered_list_store_engine.sv
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit values held in a single-port-read
// memory. A transaction is accepted when start is high and busy is low; every
// result appears for one cycle with result_valid and must be taken then.
// Requests settled at once (full, empty, bad position, push back, push front
// into an empty list, insert at the end, unused mode) give their result the
// cycle after acceptance. Other requests walk the memory one entry per cycle
// through its one registered read port: insert/push front shifts entries up,
// pop shifts entries down, delete by key searches and then removes, and
// read-out gives one result per cycle from the head. No clearing pass after
// reset: entries are only read below count.
module ordered_list_store_engine (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [olse_pkg::MODE_W-1:0]         mode,
    input  wire logic signed [olse_pkg::DATA_W-1:0]  item_value,
    input  wire logic [olse_pkg::POS_W-1:0]          position,
    output logic                                     busy,
    output logic                                     result_valid,
    output logic [olse_pkg::STATUS_W-1:0]            status,
    output logic signed [olse_pkg::DATA_W-1:0]       out_value,
    output logic [olse_pkg::ENTRY_W-1:0]             entry_count,
    output logic                                     last
);

    localparam int IDX_W  = olse_pkg::IDX_W;
    localparam int CNT_W  = olse_pkg::CNT_W;
    localparam int CMP_W  = olse_pkg::CMP_W;
    localparam int DATA_W = olse_pkg::DATA_W;

    olse_pkg::state_t   state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [DATA_W-1:0]  val_reg, val_next;
    logic [IDX_W-1:0]   tgt_reg, tgt_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic               more_reg, more_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   paddr_reg, paddr_next;
    logic [CNT_W-1:0]   step_reg, step_next;
    logic [DATA_W-1:0]  rm_reg, rm_next;
    logic               rv_reg, rv_next;
    olse_pkg::status_t  status_reg, status_next;
    logic [DATA_W-1:0]  outv_reg, outv_next;
    logic               last_reg, last_next;

    olse_pkg::mem_req_t mem_req;
    logic [DATA_W-1:0]  rdata;
    logic [IDX_W-1:0]   cnt_m1;
    logic [IDX_W-1:0]   scan_addr;
    logic [CNT_W-1:0]   ins_cnt;
    logic [CMP_W-1:0]   cnt_ext;
    logic [CMP_W-1:0]   pos_ext;
    logic               full;
    logic               empty;
    logic               key_hit;

    olse_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    assign cnt_m1  = IDX_W'(count_reg - CNT_W'(1));
    assign cnt_ext = CMP_W'(count_reg);
    assign pos_ext = CMP_W'(position);
    assign full    = (count_reg >= CNT_W'(olse_pkg::CAPACITY));
    assign empty   = (count_reg == '0);
    assign key_hit = (rdata == val_reg);

    // head first, then tail, then the middle entries in order
    always_comb
    begin
        if (step_reg == '0)
        begin
            scan_addr = '0;
        end
        else if (step_reg == CNT_W'(1))
        begin
            scan_addr = cnt_m1;
        end
        else
        begin
            scan_addr = IDX_W'(step_reg - CNT_W'(1));
        end
    end

    always_comb
    begin
        unique case (mode)
            olse_pkg::MODE_PUSH_FRONT: ins_cnt = '0;
            olse_pkg::MODE_PUSH_BACK:  ins_cnt = count_reg;
            default:                   ins_cnt = CNT_W'(position - olse_pkg::POS_W'(1));
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        val_next    = val_reg;
        tgt_next    = tgt_reg;
        ptr_next    = ptr_reg;
        more_next   = more_reg;
        pend_next   = 1'b0;
        paddr_next  = paddr_reg;
        step_next   = step_reg;
        rm_next     = rm_reg;
        rv_next     = 1'b0;
        status_next = status_reg;
        outv_next   = outv_reg;
        last_next   = last_reg;

        mem_req.we    = 1'b0;
        mem_req.waddr = '0;
        mem_req.wdata = '0;
        mem_req.raddr = ptr_reg;

        unique case (state_reg)
            olse_pkg::S_IDLE:
            begin
                if (start)
                begin
                    val_next    = item_value;
                    rv_next     = 1'b1;
                    last_next   = 1'b1;
                    outv_next   = '0;
                    status_next = olse_pkg::ST_OK;
                    unique case (mode)
                        olse_pkg::MODE_PUSH_FRONT, olse_pkg::MODE_PUSH_BACK,
                        olse_pkg::MODE_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = olse_pkg::ST_FULL;
                            end
                            else if (mode == olse_pkg::MODE_INSERT &&
                                     (position == '0 || pos_ext > cnt_ext + CMP_W'(1)))
                            begin
                                status_next = olse_pkg::ST_BADPOS;
                            end
                            else if (ins_cnt == count_reg)
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = IDX_W'(count_reg);
                                mem_req.wdata = item_value;
                                count_next    = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                rv_next    = 1'b0;
                                state_next = olse_pkg::S_SHIFT_UP;
                                tgt_next   = IDX_W'(ins_cnt);
                                ptr_next   = cnt_m1;
                                more_next  = 1'b1;
                            end
                        end
                        olse_pkg::MODE_POP_FRONT, olse_pkg::MODE_POP_BACK:
                        begin
                            if (empty)
                            begin
                                status_next = olse_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                rv_next    = 1'b0;
                                state_next = olse_pkg::S_REMOVE;
                                tgt_next   = (mode == olse_pkg::MODE_POP_FRONT) ? '0 : cnt_m1;
                                ptr_next   = (mode == olse_pkg::MODE_POP_FRONT) ? '0 : cnt_m1;
                                more_next  = 1'b1;
                            end
                        end
                        olse_pkg::MODE_DELETE_KEY:
                        begin
                            if (empty)
                            begin
                                status_next = olse_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                rv_next    = 1'b0;
                                state_next = olse_pkg::S_SCAN;
                                step_next  = '0;
                                more_next  = 1'b1;
                            end
                        end
                        olse_pkg::MODE_READ_OUT:
                        begin
                            if (empty)
                            begin
                                status_next = olse_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                rv_next    = 1'b0;
                                state_next = olse_pkg::S_READ_OUT;
                                ptr_next   = '0;
                                more_next  = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // move entries up one place, top first, then drop the new value in
            olse_pkg::S_SHIFT_UP:
            begin
                if (more_reg)
                begin
                    pend_next  = 1'b1;
                    paddr_next = ptr_reg;
                    ptr_next   = ptr_reg - IDX_W'(1);
                    more_next  = (ptr_reg != tgt_reg);
                end
                if (pend_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = paddr_reg + IDX_W'(1);
                    mem_req.wdata = rdata;
                end
                else if (!more_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = tgt_reg;
                    mem_req.wdata = val_reg;
                    count_next    = count_reg + CNT_W'(1);
                    rv_next       = 1'b1;
                    status_next   = olse_pkg::ST_OK;
                    outv_next     = '0;
                    last_next     = 1'b1;
                    state_next    = olse_pkg::S_IDLE;
                end
            end

            // first read returns the removed value, the rest move down one place
            olse_pkg::S_REMOVE:
            begin
                if (more_reg)
                begin
                    pend_next  = 1'b1;
                    paddr_next = ptr_reg;
                    ptr_next   = ptr_reg + IDX_W'(1);
                    more_next  = (ptr_reg != cnt_m1);
                end
                if (pend_reg)
                begin
                    if (paddr_reg == tgt_reg)
                    begin
                        rm_next = rdata;
                    end
                    else
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = paddr_reg - IDX_W'(1);
                        mem_req.wdata = rdata;
                    end
                    if (!more_reg)
                    begin
                        count_next  = count_reg - CNT_W'(1);
                        rv_next     = 1'b1;
                        status_next = olse_pkg::ST_OK;
                        outv_next   = (paddr_reg == tgt_reg) ? rdata : rm_reg;
                        last_next   = 1'b1;
                        state_next  = olse_pkg::S_IDLE;
                    end
                end
            end

            olse_pkg::S_SCAN:
            begin
                mem_req.raddr = scan_addr;
                if (more_reg)
                begin
                    pend_next  = 1'b1;
                    paddr_next = scan_addr;
                    step_next  = step_reg + CNT_W'(1);
                    more_next  = (step_reg + CNT_W'(1) != count_reg);
                end
                if (pend_reg)
                begin
                    if (key_hit)
                    begin
                        // the read issued this cycle is dropped
                        state_next = olse_pkg::S_REMOVE;
                        tgt_next   = paddr_reg;
                        ptr_next   = paddr_reg;
                        more_next  = 1'b1;
                        pend_next  = 1'b0;
                    end
                    else if (!more_reg)
                    begin
                        rv_next     = 1'b1;
                        status_next = olse_pkg::ST_NOTFOUND;
                        outv_next   = '0;
                        last_next   = 1'b1;
                        state_next  = olse_pkg::S_IDLE;
                    end
                end
            end

            olse_pkg::S_READ_OUT:
            begin
                if (more_reg)
                begin
                    pend_next  = 1'b1;
                    paddr_next = ptr_reg;
                    ptr_next   = ptr_reg + IDX_W'(1);
                    more_next  = (ptr_reg != cnt_m1);
                end
                if (pend_reg)
                begin
                    rv_next     = 1'b1;
                    status_next = olse_pkg::ST_OK;
                    outv_next   = rdata;
                    last_next   = (paddr_reg == cnt_m1);
                    if (paddr_reg == cnt_m1)
                    begin
                        state_next = olse_pkg::S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = olse_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= olse_pkg::S_IDLE;
            count_reg <= '0;
            more_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            more_reg  <= more_next;
            pend_reg  <= pend_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        tgt_reg    <= tgt_next;
        ptr_reg    <= ptr_next;
        paddr_reg  <= paddr_next;
        step_reg   <= step_next;
        rm_reg     <= rm_next;
        status_reg <= status_next;
        outv_reg   <= outv_next;
        last_reg   <= last_next;
    end

    assign busy         = (state_reg != olse_pkg::S_IDLE);
    assign result_valid = rv_reg;
    assign status       = status_reg;
    assign out_value    = outv_reg;
    assign entry_count  = olse_pkg::ENTRY_W'(count_reg);
    assign last         = last_reg;

    // every walk ends with its final result as the block frees up
    a_fell_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (result_valid && last))
        else $error("busy dropped without a final result");

    // read-out results come back to back until the last one
    a_readout_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |=> result_valid)
        else $error("gap inside a multi-result transaction");

    a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != olse_pkg::ST_OK) |-> last)
        else $error("failed transaction gave more than one result");

    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && full &&
         (mode == olse_pkg::MODE_PUSH_FRONT || mode == olse_pkg::MODE_PUSH_BACK))
        |=> (result_valid && status == olse_pkg::ST_FULL && $stable(count_reg)))
        else $error("push into a full list not rejected");

    a_count_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> result_valid)
        else $error("count changed without a result");

endmodule

`default_nettype wire
